FILE: design/sha1he_pkg.sv
// shared types, constants and round helpers of the sha-1 hash engine
// no dependencies; used by sha1_hash_engine_core

package sha1he_pkg;

   localparam int WORD_W     = 32;
   localparam int SLOT_W     = 4;
   localparam int ROUND_W    = 7;
   localparam int COUNT_W    = 61;
   localparam int CHAIN_N    = 5;
   localparam int HIST_N     = 8;
   localparam int NB_W       = 3;
   localparam int IDX_W      = 3;
   localparam int TDATA_W    = 40;

   localparam logic [ROUND_W-1:0] LAST_ROUND   = 7'd79;
   localparam logic [ROUND_W-1:0] EXPAND_ROUND = 7'd16;
   localparam logic [SLOT_W-1:0]  LEN_HI_SLOT  = 4'd14;
   localparam logic [SLOT_W-1:0]  LEN_LO_SLOT  = 4'd15;
   localparam logic [IDX_W-1:0]   LAST_IDX     = 3'd4;
   localparam logic [NB_W-1:0]    FULL_BYTES   = 3'd4;

   localparam logic [WORD_W-1:0] PAD_WORD = 32'h8000_0000;

   localparam logic [WORD_W-1:0] K_0 = 32'h5A82_7999;
   localparam logic [WORD_W-1:0] K_1 = 32'h6ED9_EBA1;
   localparam logic [WORD_W-1:0] K_2 = 32'h8F1B_BCDC;
   localparam logic [WORD_W-1:0] K_3 = 32'hCA62_C1D6;

   localparam logic [WORD_W-1:0] INIT_CHAIN [CHAIN_N] = '{
      32'h6745_2301, 32'hEFCD_AB89, 32'h98BA_DCFE, 32'h1032_5476, 32'hC3D2_E1F0
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_LOAD,
      ST_ROUND,
      ST_ADD,
      ST_OUTPUT
   } state_type;

   function automatic logic [WORD_W-1:0] round_const(input logic [ROUND_W-1:0] t);
      logic [WORD_W-1:0] k;
      if (t < 7'd20) begin
         k = K_0;
      end else if (t < 7'd40) begin
         k = K_1;
      end else if (t < 7'd60) begin
         k = K_2;
      end else begin
         k = K_3;
      end
      return k;
   endfunction

   function automatic logic [WORD_W-1:0] round_func(input logic [ROUND_W-1:0] t,
                                                    input logic [WORD_W-1:0] b,
                                                    input logic [WORD_W-1:0] c,
                                                    input logic [WORD_W-1:0] d);
      logic [WORD_W-1:0] f;
      if (t < 7'd20) begin
         f = (b & c) | (~b & d);
      end else if (t >= 7'd40 && t < 7'd60) begin
         f = (b & c) | (b & d) | (c & d);
      end else begin
         f = b ^ c ^ d;
      end
      return f;
   endfunction

   // partial last word: keep the valid leading bytes, pad byte right after them
   function automatic logic [WORD_W-1:0] partial_word(input logic [WORD_W-1:0] data,
                                                      input logic [NB_W-1:0] nb);
      logic [WORD_W-1:0] w;
      case (nb)
         3'd0:    w = 32'h8000_0000;
         3'd1:    w = {data[31:24], 24'h80_0000};
         3'd2:    w = {data[31:16], 16'h8000};
         3'd3:    w = {data[31:8], 8'h80};
         default: w = data;
      endcase
      return w;
   endfunction

endpackage

FILE: design/sha1_hash_engine_core.sv
// sha-1 hash engine: word intake, padding, 80-round compression and digest output
// depends on sha1he_pkg

// usage:
// req channel carries message words, first byte in bits 31..24; req_tlast marks
// the final word, whose valid leading byte count sits in req_tdata[34:32].
// every 16th word starts a block compression (one load step, 80 rounds at one per
// cycle, one chaining add); the block schedule sits in a 16-entry memory with
// two registered read ports, and the round loop sets the pace over a long message.
// words inside a block are accepted whenever req_tvalid is high; req_tready is low
// while a block is compressed, padded or the digest is sent.
// after the last word the block writes pad and length words, one per cycle,
// compresses one or two blocks, then presents five digest transfers on rsp,
// most significant word first, rsp_tlast on the fifth.
// a stalled receiver holds the current digest word; no input is taken until
// all five are transferred, after which the engine starts a new message.
// synchronous reset loads the initial chaining values and clears counters.

module sha1_hash_engine_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // data_word[31:0], valid_bytes[34:32], zero
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // digest_word[31:0], digest_index[34:32], zero
   output logic        rsp_tlast
);

   localparam int W  = sha1he_pkg::WORD_W;
   localparam int SW = sha1he_pkg::SLOT_W;
   localparam int RW = sha1he_pkg::ROUND_W;
   localparam int CW = sha1he_pkg::COUNT_W;
   localparam int NW = sha1he_pkg::NB_W;
   localparam int IW = sha1he_pkg::IDX_W;

   sha1he_pkg::state_type state_ff, state_in;

   logic [SW-1:0] slot_ff, slot_in;
   logic [CW-1:0] count_ff, count_in;
   logic [RW-1:0] round_ff, round_in;
   logic          pad_ff, pad_in;
   logic          pend80_ff, pend80_in;
   logic          hi_done_ff, hi_done_in;
   logic          lo_done_ff, lo_done_in;
   logic [IW-1:0] out_idx_ff, out_idx_in;
   logic [W-1:0]  chain_ff [sha1he_pkg::CHAIN_N];
   logic [W-1:0]  chain_in [sha1he_pkg::CHAIN_N];
   logic [W-1:0]  work_ff  [sha1he_pkg::CHAIN_N];
   logic [W-1:0]  work_in  [sha1he_pkg::CHAIN_N];
   logic [W-1:0]  hist_ff  [sha1he_pkg::HIST_N];
   logic [W-1:0]  hist_in  [sha1he_pkg::HIST_N];

   logic [W-1:0]  sched_mem [16];
   logic [W-1:0]  rd_a_ff, rd_b_ff;
   logic [SW-1:0] rd_a_addr, rd_b_addr;
   logic          mem_we;
   logic [SW-1:0] mem_waddr;
   logic [W-1:0]  mem_wdata;

   logic [W-1:0]  req_word;
   logic [NW-1:0] req_nb, nb_clamp;
   logic          req_fire, rsp_fire;
   logic [W-1:0]  sched_w, round_sum, len_hi, len_lo;

   assign req_word = req_tdata[31:0];
   assign req_nb   = req_tdata[34:32];
   assign nb_clamp = (req_nb > sha1he_pkg::FULL_BYTES) ? sha1he_pkg::FULL_BYTES : req_nb;
   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;
   assign len_hi   = count_ff[60:29];
   assign len_lo   = {count_ff[28:0], 3'b000};

   // expanded schedule word of the current round
   always_comb begin
      logic [W-1:0] x;
      x = hist_ff[2] ^ hist_ff[7] ^ rd_b_ff ^ rd_a_ff;
      if (round_ff < sha1he_pkg::EXPAND_ROUND) begin
         sched_w = rd_a_ff;
      end else begin
         sched_w = {x[W-2:0], x[W-1]};
      end
   end

   assign round_sum = {work_ff[0][W-6:0], work_ff[0][W-1:W-5]}
                      + sha1he_pkg::round_func(round_ff, work_ff[1], work_ff[2], work_ff[3])
                      + work_ff[4] + sched_w + sha1he_pkg::round_const(round_ff);

   assign rsp_tvalid = (state_ff == sha1he_pkg::ST_OUTPUT);
   assign rsp_tdata  = {5'b0, out_idx_ff, chain_ff[out_idx_ff]};
   assign rsp_tlast  = (out_idx_ff == sha1he_pkg::LAST_IDX);

   always_comb begin
      state_in   = state_ff;
      slot_in    = slot_ff;
      count_in   = count_ff;
      round_in   = round_ff;
      pad_in     = pad_ff;
      pend80_in  = pend80_ff;
      hi_done_in = hi_done_ff;
      lo_done_in = lo_done_ff;
      out_idx_in = out_idx_ff;
      chain_in   = chain_ff;
      work_in    = work_ff;
      hist_in    = hist_ff;
      req_tready = 1'b0;
      mem_we     = 1'b0;
      mem_waddr  = slot_ff;
      mem_wdata  = req_word;
      rd_a_addr  = '0;
      rd_b_addr  = 4'd2;

      case (state_ff)
         sha1he_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_fire) begin
               mem_we  = 1'b1;
               slot_in = slot_ff + 4'd1;
               if (req_tlast) begin
                  count_in  = count_ff + {{(CW-NW){1'b0}}, nb_clamp};
                  mem_wdata = sha1he_pkg::partial_word(req_word, nb_clamp);
                  pad_in    = 1'b1;
                  pend80_in = (nb_clamp == sha1he_pkg::FULL_BYTES);
                  if (slot_ff == sha1he_pkg::LEN_LO_SLOT) begin
                     state_in = sha1he_pkg::ST_LOAD;
                  end else begin
                     state_in = sha1he_pkg::ST_PAD;
                  end
               end else begin
                  count_in = count_ff + {{(CW-NW){1'b0}}, sha1he_pkg::FULL_BYTES};
                  if (slot_ff == sha1he_pkg::LEN_LO_SLOT) begin
                     state_in = sha1he_pkg::ST_LOAD;
                  end
               end
            end
         end
         sha1he_pkg::ST_PAD: begin
            mem_we  = 1'b1;
            slot_in = slot_ff + 4'd1;
            if (pend80_ff) begin
               mem_wdata = sha1he_pkg::PAD_WORD;
               pend80_in = 1'b0;
            end else if (slot_ff == sha1he_pkg::LEN_HI_SLOT) begin
               mem_wdata  = len_hi;
               hi_done_in = 1'b1;
            end else if (slot_ff == sha1he_pkg::LEN_LO_SLOT && hi_done_ff) begin
               mem_wdata  = len_lo;
               lo_done_in = 1'b1;
            end else begin
               mem_wdata = '0;
            end
            if (slot_ff == sha1he_pkg::LEN_LO_SLOT) begin
               state_in = sha1he_pkg::ST_LOAD;
            end
         end
         sha1he_pkg::ST_LOAD: begin
            work_in  = chain_ff;
            round_in = '0;
            state_in = sha1he_pkg::ST_ROUND;
         end
         sha1he_pkg::ST_ROUND: begin
            rd_a_addr = round_ff[SW-1:0] + 4'd1;
            rd_b_addr = round_ff[SW-1:0] + 4'd3;
            mem_we    = 1'b1;
            mem_waddr = round_ff[SW-1:0];
            mem_wdata = sched_w;
            work_in[0] = round_sum;
            work_in[1] = work_ff[0];
            work_in[2] = {work_ff[1][1:0], work_ff[1][W-1:2]};
            work_in[3] = work_ff[2];
            work_in[4] = work_ff[3];
            hist_in[0] = sched_w;
            for (int i = 1; i < sha1he_pkg::HIST_N; i++) begin
               hist_in[i] = hist_ff[i-1];
            end
            round_in = round_ff + 7'd1;
            if (round_ff == sha1he_pkg::LAST_ROUND) begin
               state_in = sha1he_pkg::ST_ADD;
            end
         end
         sha1he_pkg::ST_ADD: begin
            for (int i = 0; i < sha1he_pkg::CHAIN_N; i++) begin
               chain_in[i] = chain_ff[i] + work_ff[i];
            end
            if (lo_done_ff) begin
               out_idx_in = '0;
               state_in   = sha1he_pkg::ST_OUTPUT;
            end else if (pad_ff) begin
               state_in = sha1he_pkg::ST_PAD;
            end else begin
               state_in = sha1he_pkg::ST_IDLE;
            end
         end
         sha1he_pkg::ST_OUTPUT: begin
            if (rsp_fire) begin
               out_idx_in = out_idx_ff + 3'd1;
               if (out_idx_ff == sha1he_pkg::LAST_IDX) begin
                  chain_in   = sha1he_pkg::INIT_CHAIN;
                  count_in   = '0;
                  slot_in    = '0;
                  pad_in     = 1'b0;
                  pend80_in  = 1'b0;
                  hi_done_in = 1'b0;
                  lo_done_in = 1'b0;
                  state_in   = sha1he_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = sha1he_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sha1he_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff    <= '0;
         count_ff   <= '0;
         round_ff   <= '0;
         pad_ff     <= 1'b0;
         pend80_ff  <= 1'b0;
         hi_done_ff <= 1'b0;
         lo_done_ff <= 1'b0;
         out_idx_ff <= '0;
         chain_ff   <= sha1he_pkg::INIT_CHAIN;
      end else begin
         slot_ff    <= slot_in;
         count_ff   <= count_in;
         round_ff   <= round_in;
         pad_ff     <= pad_in;
         pend80_ff  <= pend80_in;
         hi_done_ff <= hi_done_in;
         lo_done_ff <= lo_done_in;
         out_idx_ff <= out_idx_in;
         chain_ff   <= chain_in;
      end
   end

   // working words and schedule history
   always_ff @(posedge clock) begin
      work_ff <= work_in;
      hist_ff <= hist_in;
   end

   // block schedule memory, one write and two registered reads per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         sched_mem[mem_waddr] <= mem_wdata;
      end
      rd_a_ff <= sched_mem[rd_a_addr];
      rd_b_ff <= sched_mem[rd_b_addr];
   end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// self-checking bench for sha1_hash_engine_core: a predictor hashes each accepted
// message word and holds the expected digest words in order
// depends on sha1he_pkg and sha1_hash_engine_core

module tb_top;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int QUIET_START  = 600;
   localparam int QUIET_END    = 1400;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 200;
   localparam int RANDOM_WORDS = 78;

   typedef struct {
      logic [sha1he_pkg::WORD_W-1:0] data;
      logic [sha1he_pkg::NB_W-1:0]   nb;
      logic                          last;
   } msg_word_type;

   typedef struct {
      logic [sha1he_pkg::WORD_W-1:0] word;
      logic [sha1he_pkg::IDX_W-1:0]  index;
      logic                          last;
   } digest_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // data_word[31:0], valid_bytes[34:32], zero
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // digest_word[31:0], digest_index[34:32], zero
   logic        rsp_tlast;

   msg_word_type word_q[$];
   digest_type   pending_digest_q[$];
   msg_word_type on_bus;

   logic [sha1he_pkg::WORD_W-1:0]  chain_h [sha1he_pkg::CHAIN_N];
   logic [sha1he_pkg::WORD_W-1:0]  sched [16];
   logic [sha1he_pkg::COUNT_W-1:0] byte_total;
   logic [sha1he_pkg::SLOT_W-1:0]  fill_slot;

   int cycle_cnt = 0;
   int words_accepted = 0;
   int digests_seen = 0;
   int hold_left = 0;
   logic hold_used = 1'b0;
   int fail_cnt = 0;
   int total_words = 0;
   int total_msgs = 0;

   sha1_hash_engine_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic logic [sha1he_pkg::WORD_W-1:0] rotl(
      input logic [sha1he_pkg::WORD_W-1:0] x, input int n);
      return (x << n) | (x >> (sha1he_pkg::WORD_W - n));
   endfunction

   task automatic start_message();
      for (int i = 0; i < sha1he_pkg::CHAIN_N; i++) begin
         chain_h[i] = sha1he_pkg::INIT_CHAIN[i];
      end
      byte_total = '0;
      fill_slot = '0;
   endtask

   task automatic compress_block();
      logic [sha1he_pkg::WORD_W-1:0] a, b, c, d, e, f, k, tmp;
      a = chain_h[0];
      b = chain_h[1];
      c = chain_h[2];
      d = chain_h[3];
      e = chain_h[4];
      for (int t = 0; t < 80; t++) begin
         if (t >= 16) begin
            sched[t % 16] = rotl(sched[(t - 3) % 16] ^ sched[(t - 8) % 16] ^
                                 sched[(t - 14) % 16] ^ sched[t % 16], 1);
         end
         if (t < 20) begin
            f = (b & c) | (~b & d);
            k = sha1he_pkg::K_0;
         end else if (t < 40) begin
            f = b ^ c ^ d;
            k = sha1he_pkg::K_1;
         end else if (t < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = sha1he_pkg::K_2;
         end else begin
            f = b ^ c ^ d;
            k = sha1he_pkg::K_3;
         end
         tmp = rotl(a, 5) + f + e + sched[t % 16] + k;
         e = d;
         d = c;
         c = rotl(b, 30);
         b = a;
         a = tmp;
      end
      chain_h[0] = chain_h[0] + a;
      chain_h[1] = chain_h[1] + b;
      chain_h[2] = chain_h[2] + c;
      chain_h[3] = chain_h[3] + d;
      chain_h[4] = chain_h[4] + e;
   endtask

   task automatic absorb(input logic [sha1he_pkg::WORD_W-1:0] w);
      sched[fill_slot] = w;
      fill_slot = fill_slot + 1'b1;
      if (fill_slot == '0) begin
         compress_block();
      end
   endtask

   task automatic hash_word(input msg_word_type item);
      logic [sha1he_pkg::NB_W-1:0]   nb;
      logic [sha1he_pkg::WORD_W-1:0] keep;
      logic [63:0]                   bit_len;
      digest_type                    dw;
      if (!item.last) begin
         byte_total = byte_total + 4;
         absorb(item.data);
      end else begin
         nb = (item.nb > sha1he_pkg::FULL_BYTES) ? sha1he_pkg::FULL_BYTES : item.nb;
         byte_total = byte_total + nb;
         if (nb == sha1he_pkg::FULL_BYTES) begin
            absorb(item.data);
            absorb(sha1he_pkg::PAD_WORD);
         end else begin
            keep = (nb == 0) ? '0 : (32'hFFFF_FFFF << (32 - 8 * int'(nb)));
            absorb((item.data & keep) | (sha1he_pkg::PAD_WORD >> (8 * int'(nb))));
         end
         while (fill_slot != sha1he_pkg::LEN_HI_SLOT) begin
            absorb('0);
         end
         bit_len = {byte_total, 3'b000};
         absorb(bit_len[63:32]);
         absorb(bit_len[31:0]);
         for (int j = 0; j < sha1he_pkg::CHAIN_N; j++) begin
            dw.word = chain_h[j];
            dw.index = sha1he_pkg::IDX_W'(j);
            dw.last = (sha1he_pkg::IDX_W'(j) == sha1he_pkg::LAST_IDX);
            pending_digest_q.push_back(dw);
         end
         start_message();
      end
   endtask

   function automatic logic take_break();
      if (cycle_cnt >= QUIET_START && cycle_cnt < QUIET_END) begin
         return 1'b0;
      end
      return $urandom_range(0, 99) < 10;
   endfunction

   task automatic push_word(input logic [sha1he_pkg::WORD_W-1:0] data,
                            input logic [sha1he_pkg::NB_W-1:0] nb,
                            input logic last);
      msg_word_type item;
      item.data = data;
      item.nb = nb;
      item.last = last;
      word_q.push_back(item);
      total_words++;
      if (last) begin
         total_msgs++;
      end
   endtask

   task automatic push_message(input int n_words, input logic [sha1he_pkg::NB_W-1:0] last_nb);
      for (int i = 0; i < n_words - 1; i++) begin
         push_word($urandom, sha1he_pkg::NB_W'($urandom_range(0, 7)), 1'b0);
      end
      push_word($urandom, last_nb, 1'b1);
   endtask

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_cnt);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            hash_word(on_bus);
            words_accepted <= words_accepted + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (word_q.size() != 0 && !take_break()) begin
               on_bus = word_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {5'b0, on_bus.nb, on_bus.data};
               req_tlast <= on_bus.last;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver, with one long hold-off once digests are flowing
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_used && rsp_tvalid && digests_seen >= 10) begin
         hold_used <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !take_break();
      end
   end

   // digest checker
   always @(posedge clock) begin
      digest_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         digests_seen <= digests_seen + 1;
         if (pending_digest_q.size() == 0) begin
            $display("%0t: unexpected digest transfer %h", $time, rsp_tdata);
            fail_cnt++;
         end else begin
            want = pending_digest_q.pop_front();
            if (rsp_tdata[31:0] !== want.word) begin
               $display("%0t: digest_word expected %h got %h", $time, want.word,
                        rsp_tdata[31:0]);
               fail_cnt++;
            end
            if (rsp_tdata[34:32] !== want.index) begin
               $display("%0t: digest_index expected %0d got %0d", $time, want.index,
                        rsp_tdata[34:32]);
               fail_cnt++;
            end
            if (rsp_tlast !== want.last) begin
               $display("%0t: digest_last expected %b got %b", $time, want.last, rsp_tlast);
               fail_cnt++;
            end
         end
      end
   end

   initial begin
      int random_words;
      int len;
      start_message();

      // empty message, unused bytes all ones
      push_word(32'hFFFF_FFFF, 3'd0, 1'b1);
      // three bytes with a junk low byte
      push_word(32'h6162_63FF, 3'd3, 1'b1);
      push_word(32'hFFFF_FFFF, 3'd1, 1'b1);
      push_word(32'hFFFF_FFFF, 3'd2, 1'b1);
      push_word(32'h0000_0000, 3'd4, 1'b1);
      // byte counts above four act as four
      push_word(32'hA5A5_5A5A, 3'd5, 1'b1);
      push_word(32'hFFFF_FFFF, 3'd6, 1'b1);
      push_word(32'h0123_4567, 3'd7, 1'b1);
      // full last word in slot 13 pushes the length into a second block
      for (int i = 0; i < 13; i++) begin
         push_word((i % 2 == 0) ? 32'hFFFF_FFFF : 32'h0000_0000,
                   sha1he_pkg::NB_W'(i % 8), 1'b0);
      end
      push_word(32'hFFFF_FFFF, 3'd4, 1'b1);

      random_words = 0;
      while (random_words < RANDOM_WORDS) begin
         len = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 16);
         if (len > RANDOM_WORDS - random_words) begin
            len = RANDOM_WORDS - random_words;
         end
         push_message(len, sha1he_pkg::NB_W'($urandom_range(0, 7)));
         random_words += len;
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (words_accepted != total_words || pending_digest_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("hashed %0d messages from %0d words, last-word byte counts 0 to 7", total_msgs,
               total_words);
      $display("compared %0d digest words, one long receiver hold-off", digests_seen);
      if (fail_cnt == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

FILE: files.f
design/sha1he_pkg.sv
design/sha1_hash_engine_core.sv
dv/tb_top.sv
